>>> sv/xesan_pkg.sv
// Shared types, codes and character tables of the XML escape and UTF-8 sanitizer.
package xesan_pkg;

    // Depth of the job queue between the classifier and the emitter.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // What follows the replacement characters of a job.
    localparam logic [1:0] BODY_NONE = 2'd0;
    localparam logic [1:0] BODY_LIT  = 2'd1;
    localparam logic [1:0] BODY_ESC  = 2'd2;

    // Entity and character reference codes.
    localparam logic [2:0] ESC_AMP  = 3'd0;
    localparam logic [2:0] ESC_LT   = 3'd1;
    localparam logic [2:0] ESC_GT   = 3'd2;
    localparam logic [2:0] ESC_QUOT = 3'd3;
    localparam logic [2:0] ESC_APOS = 3'd4;
    localparam logic [2:0] ESC_TAB  = 3'd5;
    localparam logic [2:0] ESC_LF   = 3'd6;
    localparam logic [2:0] ESC_CR   = 3'd7;

    // One queued job: rep_cnt replacement characters, then the body.
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic [1:0]  kind;
        logic [2:0]  body_len;
        logic [31:0] lit;
        logic [2:0]  esc;
        logic        text_end;
    } xesan_job_t;

    function automatic logic [2:0] esc_len(input logic [2:0] code);
        logic [2:0] len;
        unique case (code)
            ESC_LT, ESC_GT:     len = 3'd4;
            ESC_QUOT, ESC_APOS: len = 3'd6;
            default:            len = 3'd5;
        endcase
        return len;
    endfunction

    // Byte pos of the reference text, first character in the lowest byte.
    function automatic logic [7:0] esc_char(input logic [2:0] code, input logic [2:0] pos);
        logic [63:0] txt;
        unique case (code)
            ESC_AMP:  txt = {24'h0, ";", "p", "m", "a", "&"};
            ESC_LT:   txt = {32'h0, ";", "t", "l", "&"};
            ESC_GT:   txt = {32'h0, ";", "t", "g", "&"};
            ESC_QUOT: txt = {16'h0, ";", "t", "o", "u", "q", "&"};
            ESC_APOS: txt = {16'h0, ";", "s", "o", "p", "a", "&"};
            ESC_TAB:  txt = {24'h0, ";", "9", "x", "#", "&"};
            ESC_LF:   txt = {24'h0, ";", "A", "x", "#", "&"};
            default:  txt = {24'h0, ";", "D", "x", "#", "&"};
        endcase
        return txt[{pos, 3'b000} +: 8];
    endfunction

    // Bytes of U+FFFD.
    function automatic logic [7:0] rep_byte(input logic [1:0] phase);
        logic [7:0] b;
        unique case (phase)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBF;
            default: b = 8'hBD;
        endcase
        return b;
    endfunction

    // A completed sequence is acceptable when it is shortest form, no surrogate,
    // within the Unicode range and not one of the two noncharacters FFFE, FFFF.
    function automatic logic code_ok(input logic [20:0] cp, input logic [2:0] len);
        logic ok;
        ok = 1'b1;
        if ((len == 3'd2 && cp < 21'h80) || (len == 3'd3 && cp < 21'h800) ||
            (len == 3'd4 && cp < 21'h10000))
            ok = 1'b0;
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            ok = 1'b0;
        if (cp > 21'h10FFFF)
            ok = 1'b0;
        if (cp == 21'hFFFE || cp == 21'hFFFF)
            ok = 1'b0;
        return ok;
    endfunction

endpackage

>>> sv/xml_escape_utf8_sanitizer_top.sv
// Top level of the XML escape and UTF-8 sanitizer: classifier, job queue and emitter.
//
//  Channel  Direction  Transfer contents
//  s_       in         tdata[7:0] in_byte; tlast text_end
//  m_       out        tdata[7:0] out_byte; tuser[0] no_byte, tuser[1] run_last;
//                      tlast text_last
//
// The input side takes one byte per cycle whenever the four-entry job queue has room;
// a byte is classified in the cycle of its transfer and becomes at most one job.
// The emitter sends one byte per cycle while m_tready allows and sets sustained rate;
// a byte that expands to k output bytes (up to fifteen) holds it until all k are sent.
// The job queue parts the two sides, so a stalled result never blocks intake until the
// queue has filled. Reset is synchronous and active low; no clearing pass.
module xml_escape_utf8_sanitizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] no_byte, [1] run_last
    output logic       m_tlast
);

    // Jobs travel from the classifier to the emitter through the queue.
    xesan_pkg::xesan_job_t push_job;
    xesan_pkg::xesan_job_t head_job;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;

    // The classifier tracks the pending multi-byte sequence and the held bytes.
    xesan_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // The queue lets intake run ahead while a long expansion drains.
    xesan_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // The emitter walks replacements first, then the literal or escape body.
    xesan_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sv/xesan_front.sv
// Classifier: decodes UTF-8 sequences and turns each input byte into at most one queued job.
module xesan_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  q_push,
    output xesan_pkg::xesan_job_t q_job
);

    logic [2:0]  len_reg, len_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [20:0] acc_reg, acc_next;
    logic [7:0]  held_reg [3];

    logic        accept;
    logic        held_we;
    logic [1:0]  held_idx;
    logic        pending;
    logic [2:0]  cnt_plus;
    logic [20:0] acc_cont;
    logic [2:0]  pre;
    logic [7:0]  c;
    xesan_pkg::xesan_job_t job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign pending  = (len_reg != 3'd0);
    assign cnt_plus = {1'b0, cnt_reg} + 3'd1;
    assign acc_cont = {acc_reg[14:0], c[5:0]};

    always_comb begin
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        held_we       = 1'b0;
        held_idx      = cnt_reg;
        pre           = 3'd0;
        job.rep_cnt   = 3'd0;
        job.kind      = xesan_pkg::BODY_NONE;
        job.body_len  = 3'd0;
        job.lit       = 32'h0;
        job.esc       = xesan_pkg::ESC_AMP;
        job.text_end  = s_tlast;
        if (pending && c[7:6] == 2'b10) begin
            acc_next = acc_cont;
            if (cnt_plus >= len_reg) begin
                if (xesan_pkg::code_ok(acc_cont, len_reg)) begin
                    job.kind     = xesan_pkg::BODY_LIT;
                    job.body_len = cnt_plus;
                    job.lit[7:0]   = held_reg[0];
                    job.lit[15:8]  = (cnt_reg == 2'd1) ? c : held_reg[1];
                    job.lit[23:16] = (cnt_reg == 2'd2) ? c : held_reg[2];
                    job.lit[31:24] = c;
                end else begin
                    job.rep_cnt = len_reg;
                end
                len_next = 3'd0;
                cnt_next = 2'd0;
                acc_next = 21'h0;
            end else begin
                held_we  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
            end
        end else begin
            // A byte that breaks a pending sequence flushes it, then is decoded afresh.
            pre      = pending ? {1'b0, cnt_reg} : 3'd0;
            len_next = 3'd0;
            cnt_next = 2'd0;
            acc_next = 21'h0;
            job.rep_cnt = pre;
            if (!c[7]) begin
                job.kind = xesan_pkg::BODY_ESC;
                unique case (c)
                    8'h26:   job.esc = xesan_pkg::ESC_AMP;
                    8'h3C:   job.esc = xesan_pkg::ESC_LT;
                    8'h3E:   job.esc = xesan_pkg::ESC_GT;
                    8'h22:   job.esc = xesan_pkg::ESC_QUOT;
                    8'h27:   job.esc = xesan_pkg::ESC_APOS;
                    8'h09:   job.esc = xesan_pkg::ESC_TAB;
                    8'h0A:   job.esc = xesan_pkg::ESC_LF;
                    8'h0D:   job.esc = xesan_pkg::ESC_CR;
                    default: begin
                        if (c < 8'h20 || c == 8'h7F) begin
                            job.kind = xesan_pkg::BODY_NONE;
                        end else begin
                            job.kind     = xesan_pkg::BODY_LIT;
                            job.body_len = 3'd1;
                            job.lit      = {24'h0, c};
                        end
                    end
                endcase
                if (job.kind == xesan_pkg::BODY_ESC)
                    job.body_len = xesan_pkg::esc_len(job.esc);
            end else begin
                priority if (c[7:5] == 3'b110) begin
                    len_next = 3'd2;
                    acc_next = {16'h0, c[4:0]};
                end else if (c[7:4] == 4'b1110) begin
                    len_next = 3'd3;
                    acc_next = {17'h0, c[3:0]};
                end else if (c[7:3] == 5'b11110) begin
                    len_next = 3'd4;
                    acc_next = {18'h0, c[2:0]};
                end else begin
                    job.rep_cnt = pre + 3'd1;
                end
                if (len_next != 3'd0) begin
                    held_we  = 1'b1;
                    held_idx = 2'd0;
                    cnt_next = 2'd1;
                end
            end
        end
        // Text ends inside a sequence: every held byte becomes a replacement.
        if (s_tlast && len_next != 3'd0) begin
            job.rep_cnt = job.rep_cnt + {1'b0, cnt_next};
            len_next    = 3'd0;
            cnt_next    = 2'd0;
            acc_next    = 21'h0;
        end
    end

    assign q_job  = job;
    assign q_push = accept &&
                    (job.rep_cnt != 3'd0 || job.kind != xesan_pkg::BODY_NONE || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 3'd0;
            cnt_reg <= 2'd0;
            acc_reg <= 21'h0;
        end else if (accept) begin
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && held_we)
            held_reg[held_idx] <= c;
    end

endmodule

>>> sv/xesan_queue.sv
// Short job queue between the classifier and the emitter.
module xesan_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  xesan_pkg::xesan_job_t push_job,
    output logic                  full,
    input  logic                  pop,
    output xesan_pkg::xesan_job_t head_job,
    output logic                  empty
);

    xesan_pkg::xesan_job_t        slot_reg [xesan_pkg::QDEPTH];
    logic [xesan_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [xesan_pkg::QCNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == xesan_pkg::QCNT_W'(xesan_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= xesan_pkg::QCNT_W'(xesan_pkg::QDEPTH))
        else $error("job queue count out of range");

endmodule

>>> sv/xesan_back.sv
// Emitter: expands the job at the queue head into output bytes, one per cycle while m_tready allows.
module xesan_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  xesan_pkg::xesan_job_t head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic [2:0] rep_idx_reg;
    logic [1:0] phase_reg;
    logic [2:0] bpos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       nob_reg, run_last_reg, text_last_reg;

    logic       step;
    logic       in_rep;
    logic       last_rep;
    logic       is_last;
    logic [7:0] cur_byte;

    assign step     = !q_empty && (!valid_reg || m_tready);
    assign in_rep   = (rep_idx_reg < head.rep_cnt);
    assign last_rep = (rep_idx_reg == head.rep_cnt - 3'd1) && (phase_reg == 2'd2);

    always_comb begin
        if (in_rep) begin
            cur_byte = xesan_pkg::rep_byte(phase_reg);
            is_last  = last_rep && (head.kind == xesan_pkg::BODY_NONE);
        end else begin
            unique case (head.kind)
                xesan_pkg::BODY_LIT: cur_byte = head.lit[{bpos_reg[1:0], 3'b000} +: 8];
                xesan_pkg::BODY_ESC: cur_byte = xesan_pkg::esc_char(head.esc, bpos_reg);
                default:             cur_byte = 8'h00;
            endcase
            is_last = (head.kind == xesan_pkg::BODY_NONE) ||
                      (bpos_reg == head.body_len - 3'd1);
        end
    end

    assign q_pop = step && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_idx_reg <= 3'd0;
            phase_reg   <= 2'd0;
            bpos_reg    <= 3'd0;
            valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                valid_reg <= 1'b1;
                if (is_last) begin
                    rep_idx_reg <= 3'd0;
                    phase_reg   <= 2'd0;
                    bpos_reg    <= 3'd0;
                end else if (in_rep) begin
                    if (phase_reg == 2'd2) begin
                        phase_reg   <= 2'd0;
                        rep_idx_reg <= rep_idx_reg + 3'd1;
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end else begin
                    bpos_reg <= bpos_reg + 3'd1;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            byte_reg      <= cur_byte;
            nob_reg       <= !in_rep && (head.kind == xesan_pkg::BODY_NONE);
            run_last_reg  <= is_last;
            text_last_reg <= is_last && head.text_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {run_last_reg, nob_reg};
    assign m_tlast  = text_last_reg;

    a_marker_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && nob_reg |-> run_last_reg && text_last_reg)
        else $error("end marker not flagged as last of text");
    a_text_last_run: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && text_last_reg |-> run_last_reg)
        else $error("text end without run end");
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3 && rep_idx_reg <= 3'd4)
        else $error("replacement cursor out of range");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> rep_idx_reg == 3'd0 && phase_reg == 2'd0 && bpos_reg == 3'd0)
        else $error("cursor not rewound after job");

endmodule
